// File: rtl/jpeg_exif_segment_locator_macros.svh
// Assertion helpers used by the locator's top-level RTL file.
`ifndef JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH
`define JPEG_EXIF_SEGMENT_LOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/jesl_pkg.sv
package jesl_pkg;

  localparam int unsigned DefaultWindowBytes = 128 * 1024;
  localparam int unsigned MinFileBytes = 10;
  localparam int unsigned MinTiffBytes = 14;
  localparam int unsigned ExifHeadBytes = 8;

  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_APP1 = 8'hE1;

  localparam logic [7:0] BO_INTEL    = 8'h49;
  localparam logic [7:0] BO_MOTOROLA = 8'h4D;
  localparam logic [15:0] TIFF_MAGIC = 16'd42;

  localparam logic [7:0] EXIF_SIG [6] = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

  localparam logic [2:0] ST_EXIF      = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NOT_JPEG  = 3'd2;
  localparam logic [2:0] ST_NO_EXIF   = 3'd3;
  localparam logic [2:0] ST_BAD_TIFF  = 3'd4;

  typedef enum logic [2:0] {
    PH_SOI0,
    PH_SOI1,
    PH_MARK_FF,
    PH_MARK,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // Eight TIFF header bytes, entry 0 first in the file.
  typedef logic [7:0][7:0] hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] tiff_start;
    logic [15:0] tiff_length;
    logic        little_endian;
    logic [15:0] first_dir_offset;
  } tiff_res_t;

endpackage

// File: rtl/jesl_tiff_check.sv
module jesl_tiff_check
  import jesl_pkg::*;
(
  input  hdr_t        hdr,
  input  logic [15:0] seg_len,
  input  logic [16:0] last_idx,
  output tiff_res_t   res
);

  logic [15:0] tlen;
  logic        is_le;
  logic        is_be;
  logic [15:0] magic;
  logic [31:0] off;

  always_comb begin
    tlen  = seg_len - 16'(ExifHeadBytes);
    is_le = (hdr[0] == BO_INTEL) && (hdr[1] == BO_INTEL);
    is_be = (hdr[0] == BO_MOTOROLA) && (hdr[1] == BO_MOTOROLA);
    if (is_le) begin
      magic = {hdr[3], hdr[2]};
      off   = {hdr[7], hdr[6], hdr[5], hdr[4]};
    end else begin
      magic = {hdr[2], hdr[3]};
      off   = {hdr[4], hdr[5], hdr[6], hdr[7]};
    end

    res = '0;
    res.status = ST_BAD_TIFF;
    if (tlen >= 16'(MinTiffBytes) && (is_le || is_be) && magic == TIFF_MAGIC &&
        off < {16'd0, tlen}) begin
      res.status           = ST_EXIF;
      // The segment payload ends at last_idx; TIFF data follows the six-byte signature.
      res.tiff_start       = last_idx + 17'd9 - {1'b0, seg_len};
      res.tiff_length      = tlen;
      res.little_endian    = is_le;
      res.first_dir_offset = off[15:0];
    end
  end

endmodule

// File: rtl/jpeg_exif_segment_locator.sv
// Channel   Handshake                   Payload
// data      data_valid / data_ready     data_byte, last
// result    result_valid / result_ready status, tiff_start, tiff_length,
//                                       little_endian, first_dir_offset
//
// One byte is taken per cycle while data_ready is high; its result, if any, shows the next cycle.
// The marker walk and the TIFF header check both close in the byte's own cycle.
// data_ready drops only while a result waits and result_ready is low.
// rst is synchronous and returns the scanner to the start-of-image check.
`include "jpeg_exif_segment_locator_macros.svh"

module jpeg_exif_segment_locator
  import jesl_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = DefaultWindowBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [16:0] tiff_start,
  output logic [15:0] tiff_length,
  output logic        little_endian,
  output logic [15:0] first_dir_offset
);

  localparam int unsigned PosW = $clog2(WINDOW_BYTES + 1);
  localparam logic [PosW-1:0] WinEnd = PosW'(WINDOW_BYTES);

  phase_t          phase, phase_next;
  logic [PosW-1:0] pos, pos_next;
  logic [7:0]      marker, marker_next;
  logic [15:0]     seg_len, seg_len_next;
  logic [15:0]     seen, seen_next;
  logic            sig_ok, sig_ok_next;
  logic            soi_ok, soi_ok_next;
  hdr_t            hdr, hdr_next;
  logic            done, done_next;

  logic            accept;
  logic            active;
  logic [PosW-1:0] pos_inc;
  logic            app1;
  logic            sig_ok_eff;
  logic            seg_end;
  logic            judge_fire;
  logic            emit;
  tiff_res_t       judge_res;
  tiff_res_t       res_next;
  tiff_res_t       res;

  assign data_ready = !result_valid || result_ready;
  assign accept     = data_valid && data_ready;

  jesl_tiff_check u_tiff_check (
    .hdr      (hdr),
    .seg_len  (seg_len),
    .last_idx (17'(pos)),
    .res      (judge_res)
  );

  // Shared decode of the current byte.
  always_comb begin
    active     = !done && (pos < WinEnd);
    pos_inc    = active ? pos + PosW'(1) : pos;
    app1       = (marker == MK_APP1) && (seg_len >= 16'(ExifHeadBytes));
    sig_ok_eff = sig_ok;
    if (app1 && seen < 16'd6 && data_byte != EXIF_SIG[seen[2:0]]) begin
      sig_ok_eff = 1'b0;
    end
    seg_end    = (seen + 16'd1) == (seg_len - 16'd2);
    judge_fire = active && phase == PH_PAYLOAD && seg_end && app1 && sig_ok_eff;
  end

  // Marker walk.
  always_comb begin
    phase_next = phase;
    if (active) begin
      case (phase)
        PH_SOI0:    phase_next = (data_byte == MK_FILL) ? PH_SOI1 : PH_DONE;
        PH_SOI1:    phase_next = (data_byte == MK_SOI) ? PH_MARK_FF : PH_DONE;
        PH_MARK_FF: phase_next = (data_byte == MK_FILL) ? PH_MARK : PH_DONE;
        PH_MARK: begin
          if (data_byte == MK_FILL) begin
            phase_next = PH_MARK;
          end else if (data_byte inside {MK_SOI, MK_EOI, [MK_RST0:MK_RST7]}) begin
            phase_next = PH_MARK_FF;
          end else if (data_byte == MK_SOS) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: begin
          if ({seg_len[15:8], data_byte} < 16'd2) begin
            phase_next = PH_DONE;
          end else if ({seg_len[15:8], data_byte} == 16'd2) begin
            phase_next = PH_MARK_FF;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (seg_end) begin
            phase_next = judge_fire ? PH_DONE : PH_MARK_FF;
          end
        end
        default: phase_next = PH_DONE;
      endcase
    end
    if (last) begin
      phase_next = PH_SOI0;
    end
  end

  // Datapath registers and the result of this byte.
  always_comb begin
    pos_next     = pos_inc;
    marker_next  = marker;
    seg_len_next = seg_len;
    seen_next    = seen;
    sig_ok_next  = sig_ok;
    soi_ok_next  = soi_ok;
    hdr_next     = hdr;
    done_next    = done || judge_fire;
    emit         = judge_fire;
    res_next     = judge_res;

    if (active) begin
      case (phase)
        PH_SOI1: begin
          if (data_byte == MK_SOI) begin
            soi_ok_next = 1'b1;
          end
        end
        PH_MARK: marker_next = data_byte;
        PH_LEN_HI: seg_len_next = {data_byte, 8'd0};
        PH_LEN_LO: begin
          seg_len_next = {seg_len[15:8], data_byte};
          seen_next    = '0;
          sig_ok_next  = 1'b1;
          hdr_next     = '0;
        end
        PH_PAYLOAD: begin
          sig_ok_next = sig_ok_eff;
          if (app1 && seen >= 16'd6 && seen < 16'd14) begin
            hdr_next[3'(seen - 16'd6)] = data_byte;
          end
          seen_next = seen + 16'd1;
        end
        default: begin
        end
      endcase
    end

    if (last) begin
      if (!done && !judge_fire) begin
        emit     = 1'b1;
        res_next = '0;
        if (pos_inc < PosW'(MinFileBytes)) begin
          res_next.status = ST_SHORT;
        end else if (!(soi_ok || soi_ok_next)) begin
          res_next.status = ST_NOT_JPEG;
        end else begin
          res_next.status = ST_NO_EXIF;
        end
      end
      pos_next     = '0;
      marker_next  = '0;
      seg_len_next = '0;
      seen_next    = '0;
      sig_ok_next  = 1'b1;
      soi_ok_next  = 1'b0;
      hdr_next     = '0;
      done_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SOI0;
      pos     <= '0;
      marker  <= '0;
      seg_len <= '0;
      seen    <= '0;
      sig_ok  <= 1'b1;
      soi_ok  <= 1'b0;
      hdr     <= '0;
      done    <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      pos     <= pos_next;
      marker  <= marker_next;
      seg_len <= seg_len_next;
      seen    <= seen_next;
      sig_ok  <= sig_ok_next;
      soi_ok  <= soi_ok_next;
      hdr     <= hdr_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res <= res_next;
    end
  end

  assign status           = res.status;
  assign tiff_start       = res.tiff_start;
  assign tiff_length      = res.tiff_length;
  assign little_endian    = res.little_endian;
  assign first_dir_offset = res.first_dir_offset;

  `ASSERT_IMPLIES(a_done_phase, done, phase == PH_DONE,
                  "result given but scanner not stopped")
  `ASSERT_IMPLIES(a_pos_window, 1'b1, pos <= WinEnd,
                  "byte position ran past the window")
  `ASSERT_NEXT(a_judge_sets_done, accept && judge_fire && !last, done,
               "Exif result emitted without closing the file")
  `ASSERT_IMPLIES(a_exif_fields, result_valid && status == ST_EXIF,
                  tiff_length >= 16'(MinTiffBytes) && first_dir_offset < tiff_length,
                  "Exif result with inconsistent TIFF fields")
  `ASSERT_IMPLIES(a_fail_zero, result_valid && status != ST_EXIF,
                  tiff_start == '0 && tiff_length == '0 && first_dir_offset == '0 &&
                  !little_endian,
                  "failure result carries nonzero fields")

endmodule
